// ===== hdl/slil_pkg.sv =====
package slil_pkg;

    // List geometry. The field widths of the ports fix these values.
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = IDX_W + 1;

    // Operation codes.
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

endpackage

// ===== hdl/slot_indexed_list_unit.sv =====
// Walked operations (good push, remove or read) visit every slot in turn before the
// result strobe; a refused push, an out-of-range position or an unused op code is
// answered in the cycle after the accepting edge. No word is taken during a walk, which
// visits one slot per cycle, set by the single read port of the tag and value memories.
// Reset (synchronous, active low) empties the list and clears all used bits at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
module slot_indexed_list_unit import slil_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_op,
    input  logic signed [31:0]     i_value,
    input  logic [5:0]             i_position,
    output logic                   o_strobe,
    output logic signed [31:0]     o_read_data,
    output logic [6:0]             o_item_count,
    output logic [1:0]             o_status
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // Slot storage: value and tag memories, used bits in flip-flops.
    logic [DATA_WIDTH-1:0] m_value [CAPACITY];
    logic [IDX_W-1:0]      m_tag   [CAPACITY];
    logic [CAPACITY-1:0]   r_used;

    logic                  r_state;
    logic [1:0]            r_op;
    logic [DATA_WIDTH-1:0] r_value;
    logic [IDX_W-1:0]      r_pos;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_idx;
    logic                  r_s2_vld;
    logic [IDX_W-1:0]      r_s2_idx;
    logic [IDX_W-1:0]      r_tag_q;
    logic [DATA_WIDTH-1:0] r_val_q;
    logic                  r_found;
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic                  r_strobe;
    logic [31:0]           r_out_data;
    logic [CNT_W-1:0]      r_out_count;
    logic [1:0]            r_out_status;

    logic                  accept;
    logic                  slot_used;
    logic                  tag_hit;
    logic                  push_hit;
    logic                  rmv_hit;
    logic                  read_hit;
    logic                  tag_dec;
    logic                  scan_last;
    logic                  n_found;
    logic [DATA_WIDTH-1:0] n_rd_data;
    logic [CNT_W-1:0]      n_count;
    logic                  pos_range;

    assign accept    = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);
    assign pos_range = ({1'b0, i_position} >= r_count);

    // Decisions on the slot whose tag and value came back from the memories.
    assign slot_used = r_used[r_s2_idx];
    assign tag_hit   = slot_used && (r_tag_q == r_pos);
    assign push_hit  = r_s2_vld && (r_op == OP_PUSH) && !slot_used && !r_found;
    assign rmv_hit   = r_s2_vld && (r_op == OP_REMOVE) && tag_hit;
    assign read_hit  = r_s2_vld && (r_op == OP_READ) && tag_hit;
    assign tag_dec   = r_s2_vld && (r_op == OP_REMOVE) && slot_used && (r_tag_q > r_pos);
    assign scan_last = r_s2_vld && (r_s2_idx == IDX_W'(CAPACITY - 1));

    // Found flag, read data and count as they stand after this slot.
    always_comb begin
        n_found   = r_found || push_hit || rmv_hit || read_hit;
        n_rd_data = read_hit ? r_val_q : r_rd_data;
        n_count   = r_count;
        if (n_found && (r_op == OP_PUSH)) begin
            n_count = r_count + CNT_W'(1);
        end else if (n_found && (r_op == OP_REMOVE)) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Memory ports: one read per cycle at the walk index, one write at the checked slot.
    always_ff @(posedge i_clk) begin
        r_tag_q <= m_tag[r_idx[IDX_W-1:0]];
        r_val_q <= m_value[r_idx[IDX_W-1:0]];
        if (push_hit) begin
            m_value[r_s2_idx] <= r_value;
            m_tag[r_s2_idx]   <= r_count[IDX_W-1:0];
        end else if (tag_dec) begin
            m_tag[r_s2_idx]   <= r_tag_q - IDX_W'(1);
        end
    end

    // Operation payload, held for the whole walk.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_value <= i_value[DATA_WIDTH-1:0];
            r_pos   <= i_position;
        end
    end

    // Control, used bits and result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_used       <= '0;
            r_idx        <= '0;
            r_s2_vld     <= 1'b0;
            r_s2_idx     <= '0;
            r_found      <= 1'b0;
            r_rd_data    <= '0;
            r_strobe     <= 1'b0;
            r_out_data   <= '0;
            r_out_count  <= '0;
            r_out_status <= ST_OK;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        // Refused and trivial operations answer at once.
                        if ((i_op == OP_PUSH) && r_count[IDX_W]) begin
                            r_strobe     <= 1'b1;
                            r_out_data   <= '0;
                            r_out_count  <= r_count;
                            r_out_status <= ST_FULL;
                        end else if (((i_op == OP_REMOVE) || (i_op == OP_READ)) && pos_range) begin
                            r_strobe     <= 1'b1;
                            r_out_data   <= '0;
                            r_out_count  <= r_count;
                            r_out_status <= ST_RANGE;
                        end else if (i_op == OP_PUSH || i_op == OP_REMOVE || i_op == OP_READ) begin
                            r_state   <= S_SCAN;
                            r_idx     <= '0;
                            r_s2_vld  <= 1'b0;
                            r_found   <= 1'b0;
                            r_rd_data <= '0;
                        end else begin
                            r_strobe     <= 1'b1;
                            r_out_data   <= '0;
                            r_out_count  <= r_count;
                            r_out_status <= ST_OK;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue the next slot read until every slot has been visited.
                    if (!r_idx[IDX_W]) begin
                        r_idx    <= r_idx + CNT_W'(1);
                        r_s2_vld <= 1'b1;
                        r_s2_idx <= r_idx[IDX_W-1:0];
                    end else begin
                        r_s2_vld <= 1'b0;
                    end
                    r_found   <= n_found;
                    r_rd_data <= n_rd_data;
                    if (push_hit) begin
                        r_used[r_s2_idx] <= 1'b1;
                    end
                    if (rmv_hit) begin
                        r_used[r_s2_idx] <= 1'b0;
                    end
                    if (scan_last) begin
                        r_state      <= S_IDLE;
                        r_count      <= n_count;
                        r_strobe     <= 1'b1;
                        r_out_data   <= 32'(n_rd_data);
                        r_out_count  <= n_count;
                        r_out_status <= ST_OK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe     = r_strobe;
    assign o_read_data  = r_out_data;
    assign o_item_count = r_out_count;
    assign o_status     = r_out_status;

endmodule

// ===== hdl/slil_checker.sv =====
module slil_checker import slil_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input logic signed [31:0] o_read_data,
    input logic [6:0]        o_item_count,
    input logic [1:0]        o_status
);

    // A result word only follows an accepted command or a running walk.
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past((start && !busy) || busy))
        else $error("result word without a command in progress");

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_item_count <= 7'(CAPACITY)))
        else $error("item count above capacity");

    // A full status is only given when the list is really full.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_FULL)) |-> (o_item_count == 7'(CAPACITY)))
        else $error("full status with room left");

    // Nonzero read data only comes with a good status.
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_read_data != 0)) |-> (o_status == ST_OK))
        else $error("read data on a failed command");

    // A result word is never shown while busy unless busy was low the cycle before.
    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy || $past(!busy))
        else $error("busy across a result word");

endmodule

bind slot_indexed_list_unit slil_checker u_slil_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_read_data  (o_read_data),
    .o_item_count (o_item_count),
    .o_status     (o_status)
);
